[rtl/set_assoc_cache_lru_top_defines.svh]
// assertion macros used by the cache rtl datapath
`ifndef SET_ASSOC_CACHE_LRU_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SACL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sacl_pkg.sv]
package sacl_pkg;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W   = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } sacl_state_t;

  typedef struct packed {
    logic load;    // latch address, launch set read
    logic commit;  // resolve lookup, write back, load result
  } sacl_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } sacl_stat_t;

endpackage

[rtl/set_assoc_cache_lru_top.sv]
// set-associative cache tag lookup with lru replacement
//
// in_*  : one beat per memory access, in_tdata holds the 32-bit byte address
// out_* : one beat per access, hit / fill / eviction flags, set, way and tag
// cfg_* : register writes (offset bits, set index bits, ways in use), taken
//         at any edge with cfg_wr_en high; the user must write them only while the block is idle (not enforced)
//
// an accepted address is latched while its set's rows are read; the lookup
//   state then loads the result register, which raises out_tvalid
// a new access is taken only once the lookup is done; the set's tag and stamp
//   rows are read from ram in the accept cycle and written back in the lookup cycle
// the block takes the next address while a result waits in the output
//   register; when that register is still full at the end of a lookup the
//   lookup state holds until out_tready frees it
// reset: valid bits cleared at once, access timer zero, registers at their
//   defaults; tag and stamp rams need no clearing pass
module set_assoc_cache_lru_top #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // fields from bit 0: address[31:0]
  input  logic [sacl_pkg::ADDR_W-1:0]    in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: hit, filled_empty, evicted, set_number[3:0],
  // way_number[1:0], tag_value[31:0], zero fill
  output logic [sacl_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]     cfg_wdata
);
  import sacl_pkg::*;

  sacl_cmd_t  cmd;
  sacl_stat_t stat;

  // sequencer: idle / lookup
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // rams, valid bits, lru tree and result register
  sacl_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

[rtl/sacl_ram.sv]
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sacl_ctrl.sv]
module sacl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sacl_pkg::sacl_stat_t stat,
  output sacl_pkg::sacl_cmd_t  cmd
);
  import sacl_pkg::*;

  sacl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold here while the result register is full and stalled
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sacl_dp.sv]
`include "set_assoc_cache_lru_top_defines.svh"

module sacl_dp #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sacl_pkg::ADDR_W-1:0]      in_tdata,
  input  logic                             cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sacl_pkg::OUT_W-1:0]       out_tdata,
  input  sacl_pkg::sacl_cmd_t              cmd,
  output sacl_pkg::sacl_stat_t             stat
);
  import sacl_pkg::*;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int LVL    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
  localparam int P      = 1 << LVL;
  localparam int MAX_IB = $clog2(NUM_SETS + 1) - 1;
  localparam int ROW_W  = NUM_WAYS * TAG_W;
  localparam logic [3:0] MAX_IB_C = 4'(MAX_IB);
  localparam logic [4:0] NW_C     = 5'(NUM_WAYS);
  localparam int PAD_W  = OUT_W - (3 + 4 + 2 + TAG_W);

  // configuration
  logic [4:0] offset_bits_r;
  logic [2:0] set_index_bits_r;
  logic [2:0] ways_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r    <= 5'd4;
      set_index_bits_r <= 3'd2;
      ways_in_use_r    <= 3'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OFFSET_BITS:    offset_bits_r    <= cfg_wdata;
        CFG_SET_INDEX_BITS: set_index_bits_r <= cfg_wdata[2:0];
        CFG_WAYS_IN_USE:    ways_in_use_r    <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  logic [3:0]        eff_ib;
  logic [4:0]        nways;
  logic [ADDR_W-1:0] block_w;
  logic [ADDR_W-1:0] set_full;
  logic [TAG_W-1:0]  tag_w;

  assign eff_ib   = ({1'b0, set_index_bits_r} > MAX_IB_C) ? MAX_IB_C : {1'b0, set_index_bits_r};
  assign nways    = (ways_in_use_r == 3'd0) ? 5'd1 :
                    ({2'b0, ways_in_use_r} > NW_C) ? NW_C : {2'b0, ways_in_use_r};
  assign block_w  = in_tdata >> offset_bits_r;
  assign set_full = block_w & ((32'd1 << eff_ib) - 32'd1);
  assign tag_w    = block_w >> eff_ib;

  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r <= set_full[SET_W-1:0];
      tag_r <= tag_w;
    end
  end

  // tag and stamp rows, one row per set
  logic [ROW_W-1:0] tag_row, stamp_row, tag_row_nxt, stamp_row_nxt;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_r),
    .wdata (tag_row_nxt),
    .re    (cmd.load),
    .raddr (set_full[SET_W-1:0]),
    .rdata (tag_row)
  );

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_stamp_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_r),
    .wdata (stamp_row_nxt),
    .re    (cmd.load),
    .raddr (set_full[SET_W-1:0]),
    .rdata (stamp_row)
  );

  logic [NUM_WAYS-1:0] valid_r [NUM_SETS];
  logic [STAMP_W-1:0]  timer_r;
  logic [STAMP_W-1:0]  new_stamp;

  assign new_stamp = timer_r + 32'd1;

  // lookup
  logic [NUM_WAYS-1:0] vld_row, match_w, empty_w;
  logic                hit_w, filled_w;
  logic [WAY_W-1:0]    hit_way, empty_way, way_sel;
  logic [STAMP_W-1:0]  node_st  [1:2*P-1];
  logic [WAY_W-1:0]    node_idx [1:2*P-1];
  logic                node_p   [1:2*P-1];

  assign vld_row = valid_r[set_r];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match_w[w] = (5'(w) < nways) && vld_row[w] && (tag_row[w*TAG_W +: TAG_W] == tag_r);
      empty_w[w] = (5'(w) < nways) && !vld_row[w];
    end
    hit_way   = '0;
    empty_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match_w[w]) hit_way = WAY_W'(w);
      if (empty_w[w]) empty_way = WAY_W'(w);
    end
    hit_w    = |match_w;
    filled_w = !hit_w && (|empty_w);
  end

  // oldest stamp through a min tree, left side wins ties
  always_comb begin
    for (int w = 0; w < P; w++) begin
      node_p[P+w]   = 1'b0;
      node_st[P+w]  = '0;
      node_idx[P+w] = WAY_W'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      node_p[P+w]  = (5'(w) < nways);
      node_st[P+w] = stamp_row[w*STAMP_W +: STAMP_W];
    end
    for (int i = P - 1; i >= 1; i--) begin
      if (!node_p[2*i] || (node_p[2*i+1] && (node_st[2*i+1] < node_st[2*i]))) begin
        node_p[i]   = node_p[2*i+1];
        node_st[i]  = node_st[2*i+1];
        node_idx[i] = node_idx[2*i+1];
      end else begin
        node_p[i]   = node_p[2*i];
        node_st[i]  = node_st[2*i];
        node_idx[i] = node_idx[2*i];
      end
    end
  end

  always_comb begin
    if (hit_w) begin
      way_sel = hit_way;
    end else if (filled_w) begin
      way_sel = empty_way;
    end else begin
      way_sel = node_idx[1];
    end
    tag_row_nxt   = tag_row;
    stamp_row_nxt = stamp_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_sel == WAY_W'(w)) begin
        tag_row_nxt[w*TAG_W +: TAG_W]       = tag_r;
        stamp_row_nxt[w*STAMP_W +: STAMP_W] = new_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (cmd.commit) begin
      timer_r                 <= new_stamp;
      valid_r[set_r][way_sel] <= 1'b1;
    end
  end

  // result register
  logic             out_valid_r;
  logic             hit_r, filled_r, evicted_r;
  logic [3:0]       set_o_r;
  logic [1:0]       way_o_r;
  logic [TAG_W-1:0] tag_o_r;
  logic [2:0]       outcome;

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= hit_w;
      filled_r  <= filled_w;
      evicted_r <= !hit_w && !filled_w;
      set_o_r   <= 4'(set_r);
      way_o_r   <= 2'(way_sel);
      tag_o_r   <= tag_r;
    end
  end

  assign outcome    = {evicted_r, filled_r, hit_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, tag_o_r, way_o_r, set_o_r, evicted_r, filled_r, hit_r};

  `SACL_ASSERT_NEXT(a_commit_gives_result, cmd.commit, out_valid_r, "commit without result")
  `SACL_ASSERT_SAME(a_one_outcome, out_valid_r, $onehot(outcome), "result outcome not one-hot")
  `SACL_ASSERT_NEXT(a_timer_step, cmd.commit, timer_r == $past(timer_r) + 32'd1, "timer step")
  `SACL_ASSERT_SAME(a_commit_when_free, cmd.commit, stat.out_free, "result overwritten")

endmodule

[tb/cache_lookup_checker.sv]
// watches the access and result channels, predicts each lookup, compares
module cache_lookup_checker #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sacl_pkg::ADDR_W-1:0]    in_tdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sacl_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int LINES       = NUM_SETS * NUM_WAYS;
  localparam int FLOOR_LOG2  = $clog2(NUM_SETS + 1) - 1;
  localparam int MAX_IDX_BITS = (FLOOR_LOG2 > 16) ? 16 : FLOOR_LOG2;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [6:0]       pad;
    logic [TAG_W-1:0] tag;
    logic [1:0]       way;
    logic [3:0]       set;
    logic             evicted;
    logic             filled;
    logic             hit;
  } lookup_result_t;

  logic [4:0]         offset_bits_q;
  logic [2:0]         index_bits_q;
  logic [2:0]         ways_q;
  logic               line_valid [LINES];
  logic [TAG_W-1:0]   line_tag   [LINES];
  logic [STAMP_W-1:0] line_stamp [LINES];
  logic [STAMP_W-1:0] access_count;

  lookup_result_t expected_lookups [$];
  int             mismatches;
  int             result_beats;

  function automatic lookup_result_t lookup_access(input logic [ADDR_W-1:0] addr);
    logic [31:0]    blk;
    logic [31:0]    tag;
    logic [31:0]    set_sel;
    int             ib;
    int             nways;
    int             base;
    int             way;
    int             i;
    logic           hit;
    logic           filled;
    lookup_result_t r;
    blk     = addr >> offset_bits_q;
    ib      = (index_bits_q > MAX_IDX_BITS) ? MAX_IDX_BITS : int'(index_bits_q);
    nways   = (ways_q == 0) ? 1 : (ways_q > NUM_WAYS) ? NUM_WAYS : int'(ways_q);
    set_sel = blk & ((32'd1 << ib) - 32'd1);
    tag     = blk >> ib;
    base    = set_sel * NUM_WAYS;
    access_count = access_count + 1'b1;
    hit    = 1'b0;
    filled = 1'b0;
    way    = 0;
    for (i = 0; i < nways; i++)
      if (!hit && line_valid[base+i] && line_tag[base+i] == tag) begin
        hit = 1'b1;
        way = i;
      end
    if (hit) begin
      line_stamp[base+way] = access_count;
    end else begin
      for (i = 0; i < nways; i++)
        if (!filled && !line_valid[base+i]) begin
          filled = 1'b1;
          way    = i;
        end
      // lru victim, strict compare keeps the lowest way on ties
      if (!filled)
        for (i = 1; i < nways; i++)
          if (line_stamp[base+i] < line_stamp[base+way]) way = i;
      line_valid[base+way] = 1'b1;
      line_tag[base+way]   = tag;
      line_stamp[base+way] = access_count;
    end
    r.pad     = '0;
    r.tag     = tag;
    r.way     = way[1:0];
    r.set     = set_sel[3:0];
    r.evicted = !hit && !filled;
    r.filled  = filled;
    r.hit     = hit;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    lookup_result_t got;
    lookup_result_t want;
    int             i;
    if (!rst_n) begin
      offset_bits_q = 5'd4;
      index_bits_q  = 3'd2;
      ways_q        = 3'd4;
      for (i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      access_count = '0;
      expected_lookups.delete();
      mismatches   = 0;
      result_beats = 0;
    end else begin
      if (cfg_wr_en)
        case (cfg_index)
          CFG_OFFSET_BITS:    offset_bits_q = cfg_wdata[4:0];
          CFG_SET_INDEX_BITS: index_bits_q  = cfg_wdata[2:0];
          CFG_WAYS_IN_USE:    ways_q        = cfg_wdata[2:0];
          default: ;
        endcase
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        result_beats++;
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d with no lookup pending: %h", result_beats, out_tdata);
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit || got.filled !== want.filled ||
              got.evicted !== want.evicted || got.set !== want.set ||
              got.way !== want.way || got.tag !== want.tag || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result beat %0d: expected hit=%b fill=%b evict=%b set=%0d way=%0d",
                        " tag=%h pad=%h, got hit=%b fill=%b evict=%b set=%0d way=%0d",
                        " tag=%h pad=%h"}, result_beats,
                       want.hit, want.filled, want.evicted, want.set, want.way,
                       want.tag, want.pad, got.hit, got.filled, got.evicted, got.set,
                       got.way, got.tag, got.pad);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_lookups = {expected_lookups, lookup_access(in_tdata)};
    end
    fail_count    <= mismatches;
    pending_beats <= expected_lookups.size();
  end

endmodule

[tb/set_assoc_cache_lru_top_test.sv]
// stimulus and verdict for the set-associative lru cache lookup
module set_assoc_cache_lru_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SETS     = 16;
  localparam int NUM_WAYS     = 4;
  localparam int MAX_IDX_BITS = $clog2(NUM_SETS + 1) - 1;
  localparam int LIMIT_CYCLES = 1000000;  // far above the slowest legal run
  localparam int HOLD_CYCLES  = 150;      // one long receiver back-pressure stretch
  localparam int DRAIN_CYCLES = 20000;
  localparam int PHASE_ITEMS  = 165;

  // index with no register behind it, writes must be ignored
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic [sacl_pkg::ADDR_W-1:0]    in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [sacl_pkg::OUT_W-1:0]     out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_wr_en;
  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sacl_pkg::CFG_W-1:0]     cfg_wdata;
  int                             fail_count;
  int                             pending_beats;
  bit                             hold_request;

  set_assoc_cache_lru_top #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cache_lookup_checker #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender gap: mostly none or short, a few long
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mostly structured addresses: small tag pool so that sets fill up,
  // hit and evict; the rest is raw noise so every address bit toggles
  function automatic logic [31:0] random_address(input int ob, input int ib);
    logic [63:0] blk;
    logic [63:0] full;
    if ($urandom_range(0, 99) < 20) return $urandom();
    blk  = (64'($urandom_range(0, 7)) << ib) | (64'($urandom()) & ((64'd1 << ib) - 64'd1));
    full = (blk << ob) | (64'($urandom()) & ((64'd1 << ob) - 64'd1));
    return full[31:0];
  endfunction

  // one address beat; returns at the edge that accepted it
  task automatic send_access(input logic [31:0] addr, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= addr;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sacl_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait until every lookup has come out, then a few idle cycles
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reprogram the geometry while idle, then run random accesses under it
  task automatic run_phase(input logic [4:0] ob_w, input logic [4:0] sib_w,
                           input logic [4:0] ways_w, input int items, input bit steady);
    int ib;
    int n;
    write_reg(sacl_pkg::CFG_OFFSET_BITS, ob_w);
    write_reg(sacl_pkg::CFG_SET_INDEX_BITS, sib_w);
    write_reg(sacl_pkg::CFG_WAYS_IN_USE, ways_w);
    // stimulus only needs the set bits that actually select a set
    ib = (sib_w[2:0] > MAX_IDX_BITS) ? MAX_IDX_BITS : int'(sib_w[2:0]);
    for (n = 0; n < items; n++)
      send_access(random_address(int'(ob_w), ib), steady ? 0 : random_gap());
    settle();
  endtask

  // result side ready: random bursts, mostly short lows, a few long ones,
  // plus long high stretches; one forced long hold when requested
  initial begin : receiver
    int   len;
    logic level;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        level = ($urandom_range(0, 99) < 65);
        if (level)
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 12);
        else if ($urandom_range(0, 99) < 70)
          len = $urandom_range(1, 2);
        else if ($urandom_range(0, 99) < 85)
          len = $urandom_range(3, 8);
        else
          len = $urandom_range(20, 60);
        out_tready <= level;
        repeat (len) @(posedge clk);
      end
    end
  end

  // cycle limit against a hung handshake
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] directed_addrs [14];
    int          n;
    int          waited;
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    hold_request = 1'b0;

    // reset geometry: 16-byte lines, 4 sets, 4 ways
    // set 0 gets fills, a hit refresh, lru evictions; extremes and toggling patterns
    directed_addrs = '{32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                       32'h0000_0040, 32'h0000_0080, 32'h0000_00C0, 32'h0000_0100,
                       32'h0000_0040, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'hAAAA_AAAA, 32'h5555_5555};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_addrs[i]) send_access(directed_addrs[i], $urandom_range(0, 2));
    for (n = 0; n < 150; n++) send_access(random_address(4, 2), random_gap());
    settle();

    // single set, direct mapped, byte lines
    run_phase(5'd0, 5'd0, 5'd1, PHASE_ITEMS, 1'b0);
    // widest legal geometry with upper wdata bits set; long receiver hold
    // while the sender streams back to back so the input stalls
    hold_request = 1'b1;
    run_phase(5'd16, 5'd12, 5'd28, PHASE_ITEMS, 1'b1);
    // large offset, set bits saturated, way count clamped
    run_phase(5'd31, 5'd7, 5'd7, PHASE_ITEMS, 1'b0);
    // zero ways taken as one, too many sets
    run_phase(5'd2, 5'd5, 5'd0, PHASE_ITEMS, 1'b0);
    // write to the unused index must change nothing
    write_reg(CFG_UNUSED_IDX, 5'h1F);
    run_phase(5'd6, 5'd3, 5'd2, PHASE_ITEMS, 1'b0);
    run_phase(5'd20, 5'd1, 5'd3, PHASE_ITEMS, 1'b1);
    // any register value, old lines seen under the new geometry
    run_phase(5'($urandom()), 5'($urandom()), 5'($urandom()), PHASE_ITEMS, 1'b0);
    run_phase(5'($urandom()), 5'($urandom()), 5'($urandom()), PHASE_ITEMS, 1'b0);
    // back to the reset geometry with stale lines still stored
    run_phase(5'd4, 5'd2, 5'd4, PHASE_ITEMS, 1'b0);

    // final drain, bounded
    waited = 0;
    while (pending_beats != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_beats == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
